// ===== hdl/fdmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdmsd_pkg
// Types, constants and the microcode table of the fan duty map and stall
// detect unit.
// ----------------------------------------------------------------------------
package fdmsd_pkg;

	localparam int unsigned PWM_TOP_DEF     = 39;
	localparam int unsigned PERIOD_BITS_DEF = 20;
	localparam int unsigned RPM_NUM         = 30000000;
	localparam int unsigned RPM_NUM_W       = 25;
	localparam int unsigned PCT_FULL        = 100;

	localparam int unsigned ADDR_W = 5;

	// register indexes
	localparam logic [2:0] REG_TARGET_TEMP   = 3'd0;
	localparam logic [2:0] REG_DUTY_MIN      = 3'd1;
	localparam logic [2:0] REG_DUTY_MAX      = 3'd2;
	localparam logic [2:0] REG_PI_FULL_SCALE = 3'd3;
	localparam logic [2:0] REG_STALL_DUTY    = 3'd4;
	localparam logic [2:0] REG_STALL_TICKS   = 3'd5;
	localparam logic [2:0] REG_TACH_TIMEOUT  = 3'd6;

	// datapath operations
	localparam logic [2:0] OP_NONE     = 3'd0;
	localparam logic [2:0] OP_ACCEPT   = 3'd1;
	localparam logic [2:0] OP_LD_DUTY  = 3'd2;
	localparam logic [2:0] OP_DIV      = 3'd3;
	localparam logic [2:0] OP_DUTY     = 3'd4;
	localparam logic [2:0] OP_LD_CMP   = 3'd5;
	localparam logic [2:0] OP_CMP_RPM  = 3'd6;
	localparam logic [2:0] OP_FINISH   = 3'd7;

	// jump conditions
	localparam logic [2:0] COND_NEXT     = 3'd0;
	localparam logic [2:0] COND_NO_IN    = 3'd1;
	localparam logic [2:0] COND_DIV_BUSY = 3'd2;
	localparam logic [2:0] COND_OUT_BUSY = 3'd3;
	localparam logic [2:0] COND_ALWAYS   = 3'd4;

	// program steps
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_LD_DUTY  = 4'd1;
	localparam logic [3:0] ST_DIV_DUTY = 4'd2;
	localparam logic [3:0] ST_DUTY     = 4'd3;
	localparam logic [3:0] ST_LD_CMP   = 4'd4;
	localparam logic [3:0] ST_CMP_RPM  = 4'd5;
	localparam logic [3:0] ST_DIV_RPM  = 4'd6;
	localparam logic [3:0] ST_FINISH   = 4'd7;
	localparam logic [3:0] ST_RETURN   = 4'd8;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] cond;
		logic [3:0] target;
	} ctl_t;

	function automatic ctl_t ucode(input logic [3:0] step);
		ctl_t w;
		case (step)
			ST_IDLE:     w = '{op: OP_ACCEPT,  cond: COND_NO_IN,    target: ST_IDLE};
			ST_LD_DUTY:  w = '{op: OP_LD_DUTY, cond: COND_NEXT,     target: ST_IDLE};
			ST_DIV_DUTY: w = '{op: OP_DIV,     cond: COND_DIV_BUSY, target: ST_DIV_DUTY};
			ST_DUTY:     w = '{op: OP_DUTY,    cond: COND_NEXT,     target: ST_IDLE};
			ST_LD_CMP:   w = '{op: OP_LD_CMP,  cond: COND_NEXT,     target: ST_IDLE};
			ST_CMP_RPM:  w = '{op: OP_CMP_RPM, cond: COND_NEXT,     target: ST_IDLE};
			ST_DIV_RPM:  w = '{op: OP_DIV,     cond: COND_DIV_BUSY, target: ST_DIV_RPM};
			ST_FINISH:   w = '{op: OP_FINISH,  cond: COND_OUT_BUSY, target: ST_FINISH};
			ST_RETURN:   w = '{op: OP_NONE,    cond: COND_ALWAYS,   target: ST_IDLE};
			default:     w = '{op: OP_NONE,    cond: COND_ALWAYS,   target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/fan_duty_map_and_stall_detect_unit.sv =====
// ----------------------------------------------------------------------------
// fan_duty_map_and_stall_detect_unit
// Per-tick fan duty mapping, PWM compare value, tach RPM and stall flag,
// run by a microcoded sequencer over one shared restoring divider.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// tick      in         tick_valid / tick_stall      temperature, pi_output,
//                                                   edge_seen, edge_period
// res       out        res_valid / res_stall        fan_duty, compare_value,
//                                                   fan_speed_rpm, stalled
// cfg       in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
// The shared divider retires one quotient bit per cycle for the duty and RPM
// divisions; the compare value uses a reciprocal multiply.
// tick_stall is low only while the sequencer sits at its idle step.
// A finished result waits in the output register; the sequencer holds its
// finish step while res_stall keeps the previous result in place.
// arst_n clears control state and loads register defaults.
// ----------------------------------------------------------------------------
module fan_duty_map_and_stall_detect_unit
	import fdmsd_pkg::*;
#(
	parameter int unsigned PWM_TOP     = PWM_TOP_DEF,
	parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_valid,
	output logic                tick_stall,
	input  logic signed [11:0]  temperature,
	input  logic [15:0]         pi_output,
	input  logic                edge_seen,
	input  logic [19:0]         edge_period,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [6:0]          fan_duty,
	output logic [5:0]          compare_value,
	output logic [15:0]         fan_speed_rpm,
	output logic                stalled,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int unsigned PWM_W  = $clog2(PWM_TOP + 1);
	localparam int unsigned CMP_W  = 7 + PWM_W;
	localparam int unsigned PROD_W = 23;
	localparam int unsigned DIV_A  = (CMP_W > PROD_W) ? CMP_W : PROD_W;
	localparam int unsigned DIV_W  = (DIV_A > RPM_NUM_W) ? DIV_A : RPM_NUM_W;
	localparam int unsigned DVS_W  = PERIOD_BITS;
	localparam int unsigned CNT_W  = $clog2(DIV_W + 1);

	// reciprocal of 100 for the compare value
	localparam int unsigned CMP_SH = CMP_W + 7;
	localparam int unsigned REC_W  = CMP_W + 1;
	localparam int unsigned RP_W   = CMP_W + REC_W;
	localparam longint unsigned CMP_REC =
		((64'd1 << CMP_SH) + 64'(PCT_FULL) - 64'd1) / 64'(PCT_FULL);

	// configuration registers
	logic signed [11:0] target_temp_q;
	logic [6:0]         duty_min_q;
	logic [6:0]         duty_max_q;
	logic [15:0]        pi_fs_q;
	logic [6:0]         stall_duty_q;
	logic [7:0]         stall_ticks_q;
	logic [7:0]         tach_timeout_q;

	// sequencer
	logic [3:0] pc_q;
	logic [3:0] pc_d;
	ctl_t       ctl;
	logic       take;

	// state
	logic [PERIOD_BITS-1:0] period_q;
	logic                   capture_valid_q;
	logic [7:0]             silence_q;
	logic [7:0]             stall_cnt_q;
	logic                   stall_flag_q;

	// tick operands and intermediates
	logic signed [11:0] temp_q;
	logic [15:0]        pi_q;
	logic [6:0]         duty_q;
	logic [5:0]         cmp_q;

	// divider
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;

	// output register
	logic res_valid_q;

	logic cfg_wr;
	logic tick_xfer;
	logic out_free;
	logic [6:0]        span;
	logic [15:0]       fs;
	logic [PROD_W-1:0] prod;
	logic [DIV_W:0]    sum;
	logic [6:0]        duty_d;
	logic [CMP_W-1:0]  cmp_prod;
	logic [RP_W-1:0]   cmp_mul;
	logic [CMP_W-1:0]  cmp_quo;
	logic [15:0]       rpm_raw;
	logic [15:0]       rpm_d;
	logic [7:0]        sil_inc;
	logic [7:0]        sc_inc;
	logic              timed_out;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign tick_stall = (pc_q != ST_IDLE);
	assign tick_xfer  = tick_valid && !tick_stall;
	assign res_valid  = res_valid_q;
	assign out_free   = !res_valid_q || !res_stall;
	assign ctl        = ucode(pc_q);

	always_comb begin
		case (paddr[4:2])
			REG_TARGET_TEMP:   prdata = {{20{target_temp_q[11]}}, target_temp_q};
			REG_DUTY_MIN:      prdata = {25'd0, duty_min_q};
			REG_DUTY_MAX:      prdata = {25'd0, duty_max_q};
			REG_PI_FULL_SCALE: prdata = {16'd0, pi_fs_q};
			REG_STALL_DUTY:    prdata = {25'd0, stall_duty_q};
			REG_STALL_TICKS:   prdata = {24'd0, stall_ticks_q};
			REG_TACH_TIMEOUT:  prdata = {24'd0, tach_timeout_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_comb begin
		case (ctl.cond)
			COND_NO_IN:    take = !tick_valid;
			COND_DIV_BUSY: take = (cnt_q != CNT_W'(1));
			COND_OUT_BUSY: take = !out_free;
			COND_ALWAYS:   take = 1'b1;
			default:       take = 1'b0;
		endcase
		pc_d = take ? ctl.target : pc_q + 4'd1;
	end

	// arithmetic
	assign span = (duty_max_q > duty_min_q) ? (duty_max_q - duty_min_q) : 7'd0;
	assign fs   = (pi_fs_q == 16'd0) ? 16'd1 : pi_fs_q;
	assign prod = PROD_W'(pi_q) * PROD_W'(span);
	assign sum  = (DIV_W + 1)'(duty_min_q) + (DIV_W + 1)'(quo_q);

	always_comb begin
		if (sum > (DIV_W + 1)'(127)) begin
			duty_d = 7'd127;
		end else begin
			duty_d = sum[6:0];
		end
		if (duty_d > duty_max_q) begin
			duty_d = duty_max_q;
		end
		if (temp_q < target_temp_q) begin
			duty_d = 7'd0;
		end
	end

	assign cmp_prod = CMP_W'(duty_q) * CMP_W'(PWM_TOP);
	assign cmp_mul  = RP_W'(quo_q[CMP_W-1:0]) * RP_W'(CMP_REC);
	assign cmp_quo  = CMP_W'(cmp_mul >> CMP_SH);
	assign rpm_raw  = (quo_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : quo_q[15:0];
	assign sil_inc  = (silence_q == 8'hFF) ? silence_q : silence_q + 8'd1;
	assign sc_inc   = (stall_cnt_q == 8'hFF) ? stall_cnt_q : stall_cnt_q + 8'd1;
	assign timed_out = (sil_inc >= tach_timeout_q);
	assign rpm_d    = (capture_valid_q && (period_q != '0) && !timed_out) ? rpm_raw : 16'd0;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_temp_q   <= 12'sd800;
			duty_min_q      <= 7'd30;
			duty_max_q      <= 7'd100;
			pi_fs_q         <= 16'd100;
			stall_duty_q    <= 7'd25;
			stall_ticks_q   <= 8'd20;
			tach_timeout_q  <= 8'd5;
			pc_q            <= ST_IDLE;
			cnt_q           <= '0;
			period_q        <= '0;
			capture_valid_q <= 1'b0;
			silence_q       <= 8'd0;
			stall_cnt_q     <= 8'd0;
			stall_flag_q    <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[4:2])
					REG_TARGET_TEMP:   target_temp_q  <= pwdata[11:0];
					REG_DUTY_MIN:      duty_min_q     <= pwdata[6:0];
					REG_DUTY_MAX:      duty_max_q     <= pwdata[6:0];
					REG_PI_FULL_SCALE: pi_fs_q        <= pwdata[15:0];
					REG_STALL_DUTY:    stall_duty_q   <= pwdata[6:0];
					REG_STALL_TICKS:   stall_ticks_q  <= pwdata[7:0];
					REG_TACH_TIMEOUT:  tach_timeout_q <= pwdata[7:0];
					default: ;
				endcase
			end
			pc_q <= pc_d;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (ctl.op)
				OP_ACCEPT: begin
					if (tick_xfer && edge_seen) begin
						period_q        <= PERIOD_BITS'(edge_period);
						capture_valid_q <= 1'b1;
						silence_q       <= 8'd0;
					end
				end
				OP_LD_DUTY, OP_CMP_RPM: cnt_q <= CNT_W'(DIV_W);
				OP_DIV: cnt_q <= cnt_q - CNT_W'(1);
				OP_FINISH: begin
					if (out_free) begin
						silence_q   <= sil_inc;
						res_valid_q <= 1'b1;
						if (timed_out) begin
							capture_valid_q <= 1'b0;
						end
						if ((duty_q >= stall_duty_q) && (rpm_d == 16'd0)) begin
							stall_cnt_q <= sc_inc;
							if (sc_inc >= stall_ticks_q) begin
								stall_flag_q <= 1'b1;
							end
						end else begin
							stall_cnt_q  <= 8'd0;
							stall_flag_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ACCEPT: begin
				if (tick_xfer) begin
					temp_q <= temperature;
					pi_q   <= pi_output;
				end
			end
			OP_LD_DUTY: begin
				quo_q <= DIV_W'(prod);
				rem_q <= '0;
				dvs_q <= DVS_W'(fs);
			end
			OP_DIV: begin
				if (!diff[DVS_W]) begin
					rem_q <= diff[DVS_W-1:0];
				end else begin
					rem_q <= trial[DVS_W-1:0];
				end
				quo_q <= {quo_q[DIV_W-2:0], !diff[DVS_W]};
			end
			OP_DUTY: duty_q <= duty_d;
			OP_LD_CMP: quo_q <= DIV_W'(cmp_prod);
			OP_CMP_RPM: begin
				cmp_q <= (cmp_quo > CMP_W'(63)) ? 6'd63 : cmp_quo[5:0];
				quo_q <= DIV_W'(RPM_NUM);
				rem_q <= '0;
				dvs_q <= period_q;
			end
			OP_FINISH: begin
				if (out_free) begin
					fan_duty      <= duty_q;
					compare_value <= cmp_q;
					fan_speed_rpm <= rpm_d;
				end
			end
			default: ;
		endcase
	end

	assign stalled = stall_flag_q;

	a_zero_duty_zero_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && fan_duty == 7'd0) |-> (compare_value == 6'd0))
		else $error("compare value nonzero with zero duty");

	a_flag_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		stall_flag_q |-> (stall_cnt_q != 8'd0))
		else $error("stall flag set without stall count");

	a_div_only_in_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (pc_q == ST_DIV_DUTY || pc_q == ST_DIV_RPM))
		else $error("divider count live outside a divide step");

	a_tick_starts_program: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer |=> (pc_q == ST_LD_DUTY))
		else $error("tick transfer did not start the program");

endmodule
